/* hdl/cmap4_pkg.sv */
// ----------------------------------------------------------------------------
// cmap4_pkg
// Shared types and constants for the segment-map glyph lookup block.
// ----------------------------------------------------------------------------
package cmap4_pkg;

  localparam int ADDR_W = 18;
  localparam int WORD_W = 16;
  localparam int SEG_W  = 10;
  localparam int CODE_W = 21;

  localparam logic [ADDR_W-1:0] END_BASE  = ADDR_W'(7);
  localparam logic [ADDR_W-1:0] AFTER_PAD = ADDR_W'(8);

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_MISS  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic REG_SEGMENT_COUNT = 1'b0;

  typedef enum logic [2:0] {
    RD_END,
    RD_START,
    RD_DELTA,
    RD_ROFS,
    RD_GLYPH
  } rd_sel_t;

  typedef enum logic [1:0] {
    GL_ZERO,
    GL_CODE,
    GL_ARRAY
  } gl_sel_t;

  typedef struct packed {
    logic       wr_en;
    logic       load;
    logic       init;
    logic       step;
    rd_sel_t    rd_sel;
    logic       lat_start;
    logic       lat_delta;
    logic       finish;
    logic [1:0] fin_status;
    gl_sel_t    gl_sel;
  } cmd_t;

  typedef struct packed {
    logic code_big;
    logic seg_zero;
    logic searching;
    logic lo_ge_s;
    logic oob_end;
    logic oob_start;
    logic oob_delta;
    logic oob_rofs;
    logic oob_glyph;
    logic end_ge_code;
    logic start_gt_code;
    logic rofs_zero;
  } stat_t;

endpackage

/* hdl/cmap4_dp.sv */
// ----------------------------------------------------------------------------
// cmap4_dp
// Datapath: subtable memory, search bounds, segment registers, address
// generation and result registers.
// ----------------------------------------------------------------------------
module cmap4_dp #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cmap4_pkg::cmd_t                 cmd,
  input  logic [cmap4_pkg::SEG_W-1:0]     seg_count,
  input  logic [11:0]                     word_addr,
  input  logic [cmap4_pkg::WORD_W-1:0]    word_data,
  input  logic [cmap4_pkg::CODE_W-1:0]    char_code,
  output cmap4_pkg::stat_t                stat,
  output logic                            done,
  output logic [cmap4_pkg::WORD_W-1:0]    glyph_index,
  output logic [1:0]                      status
);
  import cmap4_pkg::*;

  localparam int AW = $clog2(TABLE_WORDS);

  logic [WORD_W-1:0] mem [TABLE_WORDS];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] code_q;
  logic [WORD_W-1:0] start_q;
  logic [WORD_W-1:0] delta_q;
  logic [SEG_W-1:0]  lo;
  logic [SEG_W-1:0]  hi;

  logic [SEG_W:0]    mid_sum;
  logic [SEG_W-1:0]  mid;
  logic [ADDR_W-1:0] s_ext;
  logic [ADDR_W-1:0] lo_ext;
  logic [ADDR_W-1:0] end_addr;
  logic [ADDR_W-1:0] start_addr;
  logic [ADDR_W-1:0] delta_addr;
  logic [ADDR_W-1:0] rofs_addr;
  logic [ADDR_W-1:0] glyph_addr;
  logic [WORD_W-1:0] code_diff;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_ok;
  logic [WORD_W-1:0] glyph_next;

  always_comb begin
    mid_sum    = {1'b0, lo} + {1'b0, hi};
    mid        = mid_sum[SEG_W:1];
    s_ext      = ADDR_W'(seg_count);
    lo_ext     = ADDR_W'(lo);
    end_addr   = END_BASE + ADDR_W'(mid);
    start_addr = AFTER_PAD + s_ext + lo_ext;
    delta_addr = AFTER_PAD + (s_ext << 1) + lo_ext;
    rofs_addr  = AFTER_PAD + s_ext + (s_ext << 1) + lo_ext;
    code_diff  = code_q - start_q;
    glyph_addr = rofs_addr + ADDR_W'(rdata[WORD_W-1:1]) + ADDR_W'(code_diff);
    wr_addr    = ADDR_W'(word_addr);
    wr_ok      = wr_addr < ADDR_W'(TABLE_WORDS);
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_END:   rd_addr = end_addr;
      RD_START: rd_addr = start_addr;
      RD_DELTA: rd_addr = delta_addr;
      RD_ROFS:  rd_addr = rofs_addr;
      RD_GLYPH: rd_addr = glyph_addr;
      default:  rd_addr = END_BASE;
    endcase
  end

  always_comb begin
    stat.code_big      = |char_code[CODE_W-1:WORD_W];
    stat.seg_zero      = seg_count == '0;
    stat.searching     = lo < hi;
    stat.lo_ge_s       = lo >= seg_count;
    stat.oob_end       = end_addr >= ADDR_W'(TABLE_WORDS);
    stat.oob_start     = start_addr >= ADDR_W'(TABLE_WORDS);
    stat.oob_delta     = delta_addr >= ADDR_W'(TABLE_WORDS);
    stat.oob_rofs      = rofs_addr >= ADDR_W'(TABLE_WORDS);
    stat.oob_glyph     = glyph_addr >= ADDR_W'(TABLE_WORDS);
    stat.end_ge_code   = rdata >= code_q;
    stat.start_gt_code = rdata > code_q;
    stat.rofs_zero     = rdata == '0;
  end

  always_comb begin
    unique case (cmd.gl_sel)
      GL_ZERO:  glyph_next = '0;
      GL_CODE:  glyph_next = code_q + delta_q;
      GL_ARRAY: glyph_next = (rdata == '0) ? '0 : rdata + delta_q;
      default:  glyph_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[wr_addr[AW-1:0]] <= word_data;
    end
    rdata <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_q <= char_code[WORD_W-1:0];
    end
    if (cmd.init) begin
      lo <= '0;
      hi <= seg_count;
    end else if (cmd.step) begin
      if (stat.end_ge_code) begin
        hi <= mid;
      end else begin
        lo <= mid + SEG_W'(1);
      end
    end
    if (cmd.lat_start) begin
      start_q <= rdata;
    end
    if (cmd.lat_delta) begin
      delta_q <= rdata;
    end
    if (cmd.finish) begin
      glyph_index <= glyph_next;
      status      <= cmd.fin_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

/* hdl/cmap4_ctrl.sv */
// ----------------------------------------------------------------------------
// cmap4_ctrl
// Controller: sequences the table write, the binary search over the end
// codes and the segment reads of a lookup.
// ----------------------------------------------------------------------------
module cmap4_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             mode,
  input  cmap4_pkg::stat_t stat,
  output cmap4_pkg::cmd_t  cmd,
  output logic             busy
);
  import cmap4_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_START,
    S_DELTA,
    S_ROFS,
    S_GLYPH
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_END;
    cmd.gl_sel = GL_ZERO;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (!mode) begin
            cmd.wr_en      = 1'b1;
            cmd.finish     = 1'b1;
            cmd.fin_status = STATUS_OK;
          end else begin
            cmd.load = 1'b1;
            cmd.init = 1'b1;
            if (stat.code_big || stat.seg_zero) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = STATUS_MISS;
            end else begin
              state_next = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        if (stat.searching) begin
          cmd.rd_sel = RD_END;
          if (stat.oob_end) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = STATUS_RANGE;
            state_next     = S_IDLE;
          end else begin
            state_next = S_CMP;
          end
        end else if (stat.lo_ge_s) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STATUS_MISS;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_sel = RD_START;
          if (stat.oob_start) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = STATUS_RANGE;
            state_next     = S_IDLE;
          end else begin
            state_next = S_START;
          end
        end
      end
      S_CMP: begin
        cmd.step   = 1'b1;
        state_next = S_SEARCH;
      end
      S_START: begin
        if (stat.start_gt_code) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STATUS_MISS;
          state_next     = S_IDLE;
        end else begin
          cmd.lat_start = 1'b1;
          cmd.rd_sel    = RD_DELTA;
          if (stat.oob_delta) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = STATUS_RANGE;
            state_next     = S_IDLE;
          end else begin
            state_next = S_DELTA;
          end
        end
      end
      S_DELTA: begin
        cmd.lat_delta = 1'b1;
        cmd.rd_sel    = RD_ROFS;
        if (stat.oob_rofs) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STATUS_RANGE;
          state_next     = S_IDLE;
        end else begin
          state_next = S_ROFS;
        end
      end
      S_ROFS: begin
        if (stat.rofs_zero) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STATUS_OK;
          cmd.gl_sel     = GL_CODE;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_sel = RD_GLYPH;
          if (stat.oob_glyph) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = STATUS_RANGE;
            state_next     = S_IDLE;
          end else begin
            state_next = S_GLYPH;
          end
        end
      end
      S_GLYPH: begin
        cmd.finish     = 1'b1;
        cmd.fin_status = STATUS_OK;
        cmd.gl_sel     = GL_ARRAY;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/cmap_format4_glyph_lookup_top.sv */
// ----------------------------------------------------------------------------
// cmap_format4_glyph_lookup_top
// Glyph lookup over one segment-map character-map subtable held in a word
// memory, with an APB register for the segment count.
//
// Channel   Handshake             Payload
// -------   -------------------   ---------------------------------------
// item in   start & !busy         mode, word_addr, word_data, char_code
// result    done (one cycle)      glyph_index, status
// config    psel&penable&pwrite   paddr, pwdata (prdata on reads)
//
// A table write's result follows on the next cycle.
// A lookup runs up to 10 search steps for 1023 segments (an end-code read
// and a compare each), then reads start code, delta, range offset and, if
// nonzero, a glyph word; the single-port memory's registered read sets this.
// Reset sets segment_count to 1; the table is not cleared and must be
// loaded before lookups. Results cannot be stalled.
// ----------------------------------------------------------------------------
module cmap_format4_glyph_lookup_top #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [11:0] word_addr,
  input  logic [15:0] word_data,
  input  logic [20:0] char_code,
  output logic        done,
  output logic [15:0] glyph_index,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cmap4_pkg::*;

  logic [SEG_W-1:0] seg_count;
  cmd_t             cmd;
  stat_t            stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEGMENT_COUNT) ? 32'(seg_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= SEG_W'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SEGMENT_COUNT) begin
      seg_count <= pwdata[SEG_W-1:0];
    end
  end

  cmap4_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cmap4_dp #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .seg_count   (seg_count),
    .word_addr   (word_addr),
    .word_data   (word_data),
    .char_code   (char_code),
    .stat        (stat),
    .done        (done),
    .glyph_index (glyph_index),
    .status      (status)
  );

endmodule

/* hdl/cmap4_chk.sv */
// ----------------------------------------------------------------------------
// cmap4_chk
// Port-level checks for the glyph lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module cmap4_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        mode,
  input logic [20:0] char_code,
  input logic        done,
  input logic [15:0] glyph_index,
  input logic [1:0]  status
);
  import cmap4_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result without an item");

  a_write_ack: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !mode |=> done && glyph_index == '0 && status == STATUS_OK)
    else $error("write not acknowledged next cycle");

  a_big_code: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode && char_code > 21'h00FFFF
    |=> done && glyph_index == '0 && status == STATUS_MISS)
    else $error("code above 0xFFFF not rejected");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == STATUS_OK || status == STATUS_MISS || status == STATUS_RANGE)
    else $error("bad status code");

endmodule

bind cmap_format4_glyph_lookup_top cmap4_chk u_chk (.*);

/* bench/tb_cmap_format4_glyph_lookup_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cmap_format4_glyph_lookup_top
// Self-checking bench for the segment-map glyph lookup block. A short table
// of directed items covers reset state, code limits, delta wrap, odd range
// offsets, empty array entries and out-of-table reads. Random phases then
// program several segment counts over the register port, build subtables on
// demand (every word a lookup touches is written first), and check each
// result against an in-bench model of the lookup.
// ----------------------------------------------------------------------------
module tb_cmap_format4_glyph_lookup_top;
  import cmap4_pkg::*;

  localparam int TABLE_WORDS = 4096;
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    logic [15:0] glyph;
    logic [1:0]  status;
  } glyph_result_t;

  typedef struct packed {
    logic        mode;
    logic [11:0] addr;
    logic [15:0] data;
    logic [20:0] code;
    logic        typed;
    logic [15:0] glyph;
    logic [1:0]  status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic mode;
  logic [11:0] word_addr;
  logic [15:0] word_data;
  logic [20:0] char_code;
  logic done;
  logic [15:0] glyph_index;
  logic [1:0] status;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [15:0] table_image [TABLE_WORDS];
  logic [TABLE_WORDS-1:0] word_current;
  int active_segments;
  int lay_base;
  int lay_stride;
  bit lay_tail;
  int idle_pct;

  glyph_result_t expected_glyphs [$];
  glyph_result_t exp_r;
  int mismatches;
  int items_sent;
  int lookups_sent;
  int settings_used;
  int mapped_seen;
  int miss_seen;
  int range_seen;

  stim_row_t directed_rows [0:24] = '{
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h1FFFFF, 1'b1, 16'h0, STATUS_MISS},
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h010000, 1'b1, 16'h0, STATUS_MISS},
    '{MODE_WRITE, 12'd0, 16'h0004, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'd3, 16'h0002, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'd7, 16'h00FF, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'd8, 16'h0000, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'd9, 16'h0020, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'd10, 16'h0005, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'd11, 16'h0000, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h000041, 1'b0, 16'h0, STATUS_OK},
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h0000FF, 1'b0, 16'h0, STATUS_OK},
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h000000, 1'b1, 16'h0, STATUS_MISS},
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h000100, 1'b1, 16'h0, STATUS_MISS},
    '{MODE_WRITE, 12'd10, 16'hFFFF, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h000020, 1'b0, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'd11, 16'h0003, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'd12, 16'h0000, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'd13, 16'h1234, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h000020, 1'b0, 16'h0, STATUS_OK},
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h000021, 1'b0, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'd11, 16'hFFFE, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h000020, 1'b1, 16'h0, STATUS_RANGE},
    '{MODE_LOOKUP, 12'd0, 16'h0000, 21'h00FFFF, 1'b1, 16'h0, STATUS_MISS},
    '{MODE_WRITE, 12'hFFF, 16'hFFFF, 21'h0, 1'b1, 16'h0, STATUS_OK},
    '{MODE_WRITE, 12'hFFF, 16'h0000, 21'h0, 1'b1, 16'h0, STATUS_OK}
  };

  cmap_format4_glyph_lookup_top #(
    .TABLE_WORDS(TABLE_WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .word_addr(word_addr),
    .word_data(word_data),
    .char_code(char_code),
    .done(done),
    .glyph_index(glyph_index),
    .status(status),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  // returns 1 when the lookup stops here: outside the table, or a word not
  // yet written in this phase
  function automatic bit fetch_word(input int addr, output logic [15:0] v,
                                    inout logic [1:0] stat, inout int stale);
    v = '0;
    if (addr >= TABLE_WORDS) begin
      stat = STATUS_RANGE;
      return 1'b1;
    end
    if (!word_current[addr]) begin
      stale = addr;
      return 1'b1;
    end
    v = table_image[addr];
    return 1'b0;
  endfunction

  function automatic void predict_lookup(input int code, output logic [15:0] glyph,
                                         output logic [1:0] stat, output int stale);
    int lo, hi, mid, s, rofs_addr;
    logic [15:0] v, start_w, delta_w, rofs_w;
    glyph = '0;
    stat = STATUS_MISS;
    stale = -1;
    s = active_segments;
    lo = 0;
    hi = s;
    if (code > 'hFFFF || s == 0) return;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (fetch_word(int'(END_BASE) + mid, v, stat, stale)) return;
      if (int'(v) >= code) hi = mid;
      else lo = mid + 1;
    end
    if (lo >= s) return;
    if (fetch_word(int'(AFTER_PAD) + s + lo, start_w, stat, stale)) return;
    if (int'(start_w) > code) return;
    if (fetch_word(int'(AFTER_PAD) + 2 * s + lo, delta_w, stat, stale)) return;
    rofs_addr = int'(AFTER_PAD) + 3 * s + lo;
    if (fetch_word(rofs_addr, rofs_w, stat, stale)) return;
    stat = STATUS_OK;
    if (rofs_w == 16'h0) begin
      glyph = 16'(code + int'(delta_w));
      return;
    end
    if (fetch_word(rofs_addr + int'(rofs_w >> 1) + code - int'(start_w), v, stat, stale))
      return;
    glyph = (v == 16'h0) ? 16'h0 : 16'(v + delta_w);
  endfunction

  // mostly well-formed subtable content for the current layout, some noise
  function automatic logic [15:0] layout_word(input int addr);
    int s, i;
    s = active_segments;
    if ($urandom_range(0, 15) == 0) return 16'($urandom);
    if (addr == 0) return 16'd4;
    if (addr == 3) return 16'(2 * s);
    if (addr < int'(END_BASE)) return 16'($urandom);
    if (addr < int'(END_BASE) + s) begin
      i = addr - int'(END_BASE);
      return (lay_tail && i == s - 1) ? 16'hFFFF
                                      : 16'(lay_base + i * lay_stride + lay_stride / 2);
    end
    if (addr == int'(END_BASE) + s) return 16'h0;
    if (addr < int'(AFTER_PAD) + 2 * s) begin
      i = addr - int'(AFTER_PAD) - s;
      return (lay_tail && i == s - 1) ? 16'hFFFF : 16'(lay_base + i * lay_stride);
    end
    if (addr < int'(AFTER_PAD) + 3 * s) return 16'($urandom);
    if (addr < int'(AFTER_PAD) + 4 * s) begin
      i = addr - int'(AFTER_PAD) - 3 * s;
      if ($urandom_range(0, 1) == 0) return 16'h0;
      return 16'(2 * (s - i + 4 * (i % 8)) + $urandom_range(0, 1));
    end
    return ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom);
  endfunction

  task automatic send_item(input logic m, input logic [11:0] a, input logic [15:0] d,
                           input logic [20:0] c, input logic typed,
                           input logic [15:0] tg, input logic [1:0] ts);
    glyph_result_t r;
    int stale;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    word_addr <= a;
    word_data <= d;
    char_code <= c;
    if (m == MODE_WRITE) begin
      table_image[a] = d;
      word_current[a] = 1'b1;
      r.glyph = 16'h0;
      r.status = STATUS_OK;
    end else begin
      predict_lookup(int'(c), r.glyph, r.status, stale);
      lookups_sent++;
    end
    if (typed) begin
      r.glyph = tg;
      r.status = ts;
    end
    do @(posedge clk); while (busy !== 1'b0);
    expected_glyphs.push_back(r);
    items_sent++;
  endtask

  // writes every word the lookup would touch before issuing it
  task automatic lookup_code(input logic [20:0] c);
    logic [15:0] g;
    logic [1:0] st;
    int stale;
    predict_lookup(int'(c), g, st, stale);
    while (stale >= 0) begin
      send_item(MODE_WRITE, 12'(stale), layout_word(stale), 21'($urandom), 1'b0, 16'h0,
                STATUS_OK);
      predict_lookup(int'(c), g, st, stale);
    end
    send_item(MODE_LOOKUP, 12'($urandom), 16'($urandom), c, 1'b0, 16'h0, STATUS_OK);
  endtask

  task automatic write_segment_count(input logic [9:0] s);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_SEGMENT_COUNT);
    pwdata <= {22'($urandom), s};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    active_segments = int'(s);
    settings_used++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: glyph %h status %0d", glyph_index, status);
      end else begin
        exp_r = expected_glyphs.pop_front();
        if (exp_r.glyph !== glyph_index || exp_r.status !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected glyph %h status %0d, got glyph %h status %0d",
                     exp_r.glyph, exp_r.status, glyph_index, status);
        end
        case (status)
          STATUS_OK: mapped_seen++;
          STATUS_MISS: miss_seen++;
          default: range_seen++;
        endcase
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

  initial begin : main
    int seg_plan [10];
    int s;
    int pick;
    int budget;
    int seg;
    logic [20:0] code;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= MODE_WRITE;
    word_addr <= '0;
    word_data <= '0;
    char_code <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    word_current = '0;
    active_segments = 1;
    idle_pct = 36;
    mismatches = 0;
    items_sent = 0;
    lookups_sent = 0;
    settings_used = 0;
    mapped_seen = 0;
    miss_seen = 0;
    range_seen = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k])
      send_item(directed_rows[k].mode, directed_rows[k].addr, directed_rows[k].data,
                directed_rows[k].code, directed_rows[k].typed, directed_rows[k].glyph,
                directed_rows[k].status);

    seg_plan = '{1, 0, 2, 3, 7, 8, 61, 1020, 1023, 1};
    seg_plan[5] = $urandom_range(8, 60);
    seg_plan[6] = $urandom_range(61, 1019);
    foreach (seg_plan[p]) begin
      drain();
      write_segment_count(10'(seg_plan[p]));
      s = seg_plan[p];
      if (s > 0) begin
        lay_stride = $urandom_range(2, (65000 / s < 64) ? 65000 / s : 64);
        lay_base = $urandom_range(0, 65000 - s * lay_stride);
      end
      lay_tail = $urandom_range(0, 1);
      word_current = '0;
      idle_pct = (p == 4) ? 0 : 36;
      budget = items_sent + PHASE_ITEMS;
      while (items_sent < budget) begin
        pick = $urandom_range(0, 99);
        if (pick < 75 && s > 0) begin
          seg = $urandom_range(0, s - 1);
          code = 21'(lay_base + seg * lay_stride + $urandom_range(0, lay_stride));
          lookup_code(code);
        end else if (pick < 85) begin
          code = $urandom_range(0, 1) ? 21'($urandom_range(0, 8))
                                      : 21'('hFFFF - $urandom_range(0, 8));
          lookup_code(code);
        end else if (pick < 95) begin
          lookup_code(21'($urandom));
        end else begin
          send_item(MODE_WRITE, 12'($urandom), 16'($urandom), 21'($urandom), 1'b0, 16'h0,
                    STATUS_OK);
        end
      end
    end

    start <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d items (%0d lookups) over %0d segment-count settings",
             items_sent, lookups_sent, settings_used);
    $display("results: %0d ok, %0d not covered, %0d outside table; %0d mismatches",
             mapped_seen, miss_seen, range_seen, mismatches);
    if (mismatches == 0 && expected_glyphs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/cmap4_pkg.sv
hdl/cmap4_dp.sv
hdl/cmap4_ctrl.sv
hdl/cmap_format4_glyph_lookup_top.sv
hdl/cmap4_chk.sv
bench/tb_cmap_format4_glyph_lookup_top.sv
